@@ rtl/rtwm_pkg.sv @@
// rtwm_pkg: shared types, codes and sizes for the ramped-rate time warp map.
// Used by rtwm_div, the top level and rtwm_chk; depends on nothing.
`default_nettype none
package rtwm_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;

    // divider: 81-bit dividend (span << 17), 64-bit divisor
    localparam int DIV_DW = 81;
    localparam int DIV_VW = 64;
    localparam int DIV_CW = $clog2(DIV_DW + 1);

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_OVF     = 3'd2;
    localparam logic [2:0] ST_ORDER   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [19:0]        rate_start;
        logic [19:0]        rate_end;
        logic signed [63:0] source_start;
        logic signed [63:0] source_end;
        logic signed [63:0] output_start;
        logic signed [63:0] query_time;
    } t_in;

    typedef struct packed {
        logic signed [63:0] source_frame;
        logic [2:0]         status;
        logic [4:0]         segment_count;
    } t_out;

    typedef struct packed {
        logic [19:0]        rate_start;
        logic [19:0]        rate_end;
        logic signed [63:0] source_start;
        logic signed [63:0] source_end;
        logic signed [63:0] output_start;
        logic signed [63:0] output_end;
        logic signed [47:0] rate_slope;
    } t_seg;

endpackage
`default_nettype wire

@@ rtl/rtwm_div.sv @@
// rtwm_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on rtwm_pkg for its widths.
`default_nettype none
module rtwm_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rtwm_pkg::DIV_DW-1:0] i_dividend,
    input  wire logic [rtwm_pkg::DIV_VW-1:0] i_divisor,
    output logic                             o_done,
    output logic [rtwm_pkg::DIV_DW-1:0]      o_quot
);
    logic [rtwm_pkg::DIV_VW-1:0] r_rem;
    logic [rtwm_pkg::DIV_DW-1:0] r_quo;
    logic [rtwm_pkg::DIV_VW-1:0] r_den;
    logic [rtwm_pkg::DIV_CW-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [rtwm_pkg::DIV_VW:0]   trial;
    logic [rtwm_pkg::DIV_VW:0]   diff;
    logic                        fits;

    assign trial = {r_rem, r_quo[rtwm_pkg::DIV_DW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_den  <= i_divisor;
                r_cnt  <= rtwm_pkg::DIV_CW'(rtwm_pkg::DIV_DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= fits ? diff[rtwm_pkg::DIV_VW-1:0] : trial[rtwm_pkg::DIV_VW-1:0];
                r_quo <= {r_quo[rtwm_pkg::DIV_DW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rtwm_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

@@ rtl/rtwm_mul.sv @@
// rtwm_mul: 64x64 unsigned multiplier built from four 32x32 partial products.
// Standalone; the top level shares it between both query multiplies.
`default_nettype none
module rtwm_mul (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic              o_done,
    output logic [127:0]      o_prod
);
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [1:0]   r_step;
    logic         r_busy;
    logic         r_done;
    logic [31:0]  pa;
    logic [31:0]  pb;
    logic [63:0]  pp;
    logic [6:0]   sh;

    assign pa = r_step[0] ? r_a[63:32] : r_a[31:0];
    assign pb = r_step[1] ? r_b[63:32] : r_b[31:0];
    assign pp = pa * pb;
    assign sh = 7'({1'b0, r_step[0]} + {1'b0, r_step[1]}) << 5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc  <= r_acc + (128'(pp) << sh);
                r_step <= r_step + 1'b1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule
`default_nettype wire

@@ rtl/ramped_rate_time_warp_map.sv @@
// ramped_rate_time_warp_map: segment table mapping output time to source position.
// Depends on rtwm_pkg, rtwm_div and rtwm_mul.
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_in_data  (rtwm_pkg::t_in)
// result    out        o_out_valid / i_out_ready  o_out_data (rtwm_pkg::t_out)
//
// Clear and unused kinds go from dispatch straight to the result state. An append
// runs the bit-serial divider twice (duration, then slope), skipping the slope
// pass for a zero duration. A query walks the table entries through the registered
// memory read, then uses the shared multiplier once past the end, else twice.
// Reset is synchronous; the table needs no clearing pass, only the count resets.
// A new item is taken while the last result still waits at the output.
`default_nettype none
module ramped_rate_time_warp_map #(
    parameter int MAX_SEGMENTS = rtwm_pkg::MAX_SEGMENTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rtwm_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rtwm_pkg::t_out     o_out_data
);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_ADIV  = 10'b0000000100,
        S_ASLP  = 10'b0000001000,
        S_AFIN  = 10'b0000010000,
        S_QRD   = 10'b0000100000,
        S_QCHK  = 10'b0001000000,
        S_QMUL1 = 10'b0010000000,
        S_QMUL2 = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    rtwm_pkg::t_in  r_in, n_in;
    rtwm_pkg::t_out r_out, n_out;
    logic          r_ov, n_ov;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic [63:0]   r_last_end, n_last_end;
    logic [63:0]   r_end, n_end;
    logic [47:0]   r_slope, n_slope;
    logic [2:0]    r_status, n_status;
    logic [63:0]   r_frame, n_frame;
    logic [63:0]   r_dm, n_dm;
    logic          r_dn, n_dn;
    logic          r_sn, n_sn;
    logic          r_neg, n_neg;
    logic          r_past, n_past;
    logic [63:0]   r_base, n_base;

    rtwm_pkg::t_seg r_mem [MAX_SEGMENTS];
    rtwm_pkg::t_seg r_rd;
    rtwm_pkg::t_seg seg_wdata;
    logic           seg_we;

    logic                        div_start, div_done;
    logic [rtwm_pkg::DIV_DW-1:0] div_a, div_q;
    logic [rtwm_pkg::DIV_VW-1:0] div_b;
    logic                        mul_start, mul_done;
    logic [63:0]                 mul_a, mul_b;
    logic [127:0]                mul_p;

    // combinational helpers
    logic [63:0]  span;
    logic         rsneg;
    logic [19:0]  rdm;
    logic [64:0]  end_sum;
    logic [64:0]  qdiff;
    logic [64:0]  qdiff_neg;
    logic [47:0]  smag;
    logic         tsat;
    logic [62:0]  tm;
    logic [63:0]  term;
    logic [63:0]  rate;
    logic [63:0]  rmag;
    logic         slope_ovf;
    logic [CW:0]  idx_next;

    function automatic logic [63:0] sat_add(logic [63:0] base, logic neg,
                                            logic hi_nz, logic [63:0] lo);
        logic [65:0] s;
        logic [63:0] res;
        s = neg ? ({{2{base[63]}}, base} - {2'b0, lo})
                : ({{2{base[63]}}, base} + {2'b0, lo});
        if (hi_nz) begin
            res = neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else if (s[65:63] != 3'b000 && s[65:63] != 3'b111) begin
            res = s[65] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
            res = s[63:0];
        end
        return res;
    endfunction

    rtwm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    rtwm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    assign seg_wdata = '{rate_start:   r_in.rate_start,
                         rate_end:     r_in.rate_end,
                         source_start: r_in.source_start,
                         source_end:   r_in.source_end,
                         output_start: r_in.output_start,
                         output_end:   r_end,
                         rate_slope:   r_slope};

    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            r_mem[r_count[IW-1:0]] <= seg_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    assign span      = r_in.source_end - r_in.source_start;
    assign rsneg     = r_in.rate_end < r_in.rate_start;
    assign rdm       = rsneg ? (r_in.rate_start - r_in.rate_end)
                             : (r_in.rate_end - r_in.rate_start);
    assign end_sum   = {r_in.output_start[63], r_in.output_start} + {2'b0, div_q[62:0]};
    assign slope_ovf = (div_q[80:48] != '0)
                    || (div_q[47] && (!rsneg || div_q[46:0] != '0));
    assign qdiff     = {r_in.query_time[63], r_in.query_time}
                     - {r_rd.output_start[63], r_rd.output_start};
    assign qdiff_neg = -qdiff;
    assign smag      = r_rd.rate_slope[47] ? (48'd0 - r_rd.rate_slope) : r_rd.rate_slope;
    // half-slope term, magnitude held at 2^62
    assign tsat      = (mul_p[127:80] != '0) || (mul_p[79] && mul_p[78:17] != '0);
    assign tm        = tsat ? (63'd1 << 62) : mul_p[79:17];
    assign term      = (r_sn != r_dn) ? (64'd0 - {1'b0, tm}) : {1'b0, tm};
    assign rate      = {16'b0, r_rd.rate_start, 28'b0} + term;
    assign rmag      = rate[63] ? (64'd0 - rate) : rate;
    assign idx_next  = (CW+1)'(r_idx) + 1'b1;

    always_comb begin
        n_state    = r_state;
        n_in       = r_in;
        n_out      = r_out;
        n_ov       = r_ov && !i_out_ready;
        n_count    = r_count;
        n_idx      = r_idx;
        n_last_end = r_last_end;
        n_end      = r_end;
        n_slope    = r_slope;
        n_status   = r_status;
        n_frame    = r_frame;
        n_dm       = r_dm;
        n_dn       = r_dn;
        n_sn       = r_sn;
        n_neg      = r_neg;
        n_past     = r_past;
        n_base     = r_base;
        seg_we     = 1'b0;
        div_start  = 1'b0;
        div_a      = '0;
        div_b      = '0;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_frame  = '0;
                n_status = rtwm_pkg::ST_OK;
                case (r_in.kind)
                    rtwm_pkg::KIND_CLEAR: begin
                        n_count = '0;
                        n_state = S_DONE;
                    end
                    rtwm_pkg::KIND_APPEND: begin
                        if (r_in.rate_start == '0 || r_in.rate_end == '0
                                || r_in.source_end < r_in.source_start) begin
                            n_status = rtwm_pkg::ST_INVALID;
                            n_state  = S_DONE;
                        end else begin
                            div_start = 1'b1;
                            div_a     = {span, 17'b0};
                            div_b     = {43'b0, 21'(r_in.rate_start) + 21'(r_in.rate_end)};
                            n_state   = S_ADIV;
                        end
                    end
                    rtwm_pkg::KIND_QUERY: begin
                        if (r_count == '0) begin
                            n_frame = r_in.query_time;
                            n_state = S_DONE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_QRD;
                        end
                    end
                    default: begin
                        n_status = rtwm_pkg::ST_INVALID;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_ADIV: begin
                if (div_done) begin
                    if (div_q[80:63] != '0 || end_sum[64] != end_sum[63]) begin
                        n_status = rtwm_pkg::ST_OVF;
                        n_state  = S_DONE;
                    end else begin
                        n_end = end_sum[63:0];
                        if (div_q[62:0] == '0) begin
                            n_slope = '0;
                            n_state = S_AFIN;
                        end else begin
                            div_start = 1'b1;
                            div_a     = {17'b0, rdm, 44'b0};
                            div_b     = {1'b0, div_q[62:0]};
                            n_state   = S_ASLP;
                        end
                    end
                end
            end
            S_ASLP: begin
                if (div_done) begin
                    if (slope_ovf) begin
                        n_status = rtwm_pkg::ST_OVF;
                        n_state  = S_DONE;
                    end else begin
                        n_slope = rsneg ? (48'd0 - div_q[47:0]) : div_q[47:0];
                        n_state = S_AFIN;
                    end
                end
            end
            S_AFIN: begin
                n_state = S_DONE;
                if (r_count != '0 && $signed(r_end) < $signed(r_last_end)) begin
                    n_status = rtwm_pkg::ST_ORDER;
                end else if (r_count >= CW'(MAX_SEGMENTS)) begin
                    n_status = rtwm_pkg::ST_FULL;
                end else begin
                    seg_we     = 1'b1;
                    n_count    = r_count + 1'b1;
                    n_last_end = r_end;
                end
            end
            S_QRD: begin
                n_state = S_QCHK;
            end
            S_QCHK: begin
                if (idx_next < (CW+1)'(r_count)
                        && r_rd.output_end <= r_in.query_time) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_QRD;
                end else if (r_rd.output_end <= r_in.query_time) begin
                    // past the last segment: extrapolate at the end rate
                    n_past    = 1'b1;
                    n_neg     = 1'b0;
                    n_base    = r_rd.source_end;
                    mul_start = 1'b1;
                    mul_a     = r_in.query_time - r_rd.output_end;
                    mul_b     = {44'b0, r_rd.rate_end};
                    n_state   = S_QMUL2;
                end else begin
                    n_past    = 1'b0;
                    n_dn      = qdiff[64];
                    n_dm      = qdiff[64] ? qdiff_neg[63:0] : qdiff[63:0];
                    n_sn      = r_rd.rate_slope[47];
                    mul_start = 1'b1;
                    mul_a     = {16'b0, smag};
                    mul_b     = qdiff[64] ? qdiff_neg[63:0] : qdiff[63:0];
                    n_state   = S_QMUL1;
                end
            end
            S_QMUL1: begin
                if (mul_done) begin
                    n_neg     = r_dn != rate[63];
                    n_base    = r_rd.source_start;
                    mul_start = 1'b1;
                    mul_a     = r_dm;
                    mul_b     = rmag;
                    n_state   = S_QMUL2;
                end
            end
            S_QMUL2: begin
                if (mul_done) begin
                    if (r_past) begin
                        n_frame = sat_add(r_base, r_neg, mul_p[127:80] != '0, mul_p[79:16]);
                    end else begin
                        n_frame = sat_add(r_base, r_neg, mul_p[127:108] != '0,
                                          mul_p[107:44]);
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register frees up
                if (!r_ov || i_out_ready) begin
                    n_out   = '{source_frame: r_frame, status: r_status,
                                segment_count: 5'(r_count)};
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_out      <= n_out;
        r_last_end <= n_last_end;
        r_end      <= n_end;
        r_slope    <= n_slope;
        r_status   <= n_status;
        r_frame    <= n_frame;
        r_dm       <= n_dm;
        r_dn       <= n_dn;
        r_sn       <= n_sn;
        r_neg      <= n_neg;
        r_past     <= n_past;
        r_base     <= n_base;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

@@ rtl/rtwm_chk.sv @@
// rtwm_chk: port-level assertions for ramped_rate_time_warp_map, bound to the top.
// Depends on rtwm_pkg for the payload types and codes.
`default_nettype none
module rtwm_chk #(
    parameter int MAX_SEGMENTS = rtwm_pkg::MAX_SEGMENTS_DEF
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire rtwm_pkg::t_in  i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire rtwm_pkg::t_out o_out_data
);
    // busy after every accepted transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transaction");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.segment_count <= MAX_SEGMENTS))
        else $error("segment count above table size");

    a_frame_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != rtwm_pkg::ST_OK) |-> o_out_data.source_frame == 0)
        else $error("source frame set on a failed transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // a clear taken while no result waits reports an empty table
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.kind == rtwm_pkg::KIND_CLEAR && !o_out_valid)
        |=> ##2 (o_out_valid && o_out_data.segment_count == 0))
        else $error("clear left segments in the table");
endmodule

bind ramped_rate_time_warp_map rtwm_chk #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_rtwm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
